@@ hdl/pvr_pkg.sv @@
// Shared types, codes and defaults of the path vector route table.
`default_nettype none
package pvr_pkg;

    localparam int PVR_NODES_DEF = 64;

    localparam logic [1:0] OP_PATH     = 2'd0;
    localparam logic [1:0] OP_WITHDRAW = 2'd1;
    localparam logic [1:0] OP_LOST     = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] neighbor;
        logic [5:0] dest;
        logic [5:0] hop_node;
        logic       last;
    } pvr_in_t;

    typedef struct packed {
        logic       changed;
        logic [5:0] dest_out;
        logic [5:0] next_hop;
        logic [6:0] hops;
        logic       reachable;
        logic       last_out;
    } pvr_out_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_ROUTE,
        K_LOST
    } pvr_kind_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BRD,
        S_BDEC,
        S_SCAN,
        S_SFIN,
        S_SWR,
        S_EMIT,
        S_NRD,
        S_NDEC,
        S_PUSH,
        S_NEND
    } pvr_state_t;

    typedef struct packed {
        logic take;
        logic cfg_take;
        logic clr;
        logic bdec;
        logic scan_run;
        logic swr;
        logic emit;
        logic ndec;
        logic d_next;
        logic push;
        logic flush;
    } pvr_cmd_t;

    typedef struct packed {
        logic      clr_done;
        pvr_kind_t kind;
        logic      bdec_scan;
        logic      ndec_scan;
        logic      d_last;
        logic      scan_last;
        logic      out_free;
        logic      pend_valid;
    } pvr_stat_t;

endpackage
`default_nettype wire

@@ hdl/pvr_ctrl.sv @@
// Sequencer of the route table: clearing, route update, neighbor loss and result hand-off.
`default_nettype none
module pvr_ctrl
    import pvr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire pvr_stat_t stat,
    output pvr_cmd_t       cmd
);

    pvr_state_t state_reg, state_next;
    logic       lost_reg, lost_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            lost_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            lost_reg  <= lost_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        lost_next  = lost_reg;
        unique case (state_reg)
            S_CLEAR: if (stat.clr_done) state_next = S_IDLE;
            S_IDLE: begin
                if (cfg_valid) begin
                    state_next = S_CLEAR;
                end else if (s_valid) begin
                    unique case (stat.kind)
                        K_ROUTE: begin
                            state_next = S_BRD;
                            lost_next  = 1'b0;
                        end
                        K_LOST: begin
                            state_next = S_NRD;
                            lost_next  = 1'b1;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_BRD:  state_next = S_BDEC;
            S_BDEC: state_next = stat.bdec_scan ? S_SCAN : S_EMIT;
            S_SCAN: if (stat.scan_last) state_next = S_SFIN;
            S_SFIN: state_next = S_SWR;
            S_SWR:  state_next = lost_reg ? S_PUSH : S_EMIT;
            S_EMIT: if (stat.out_free) state_next = S_IDLE;
            S_NRD:  state_next = S_NDEC;
            S_NDEC: begin
                if (stat.ndec_scan)   state_next = S_SCAN;
                else if (stat.d_last) state_next = S_NEND;
                else                  state_next = S_NRD;
            end
            S_PUSH: begin
                if (!stat.pend_valid || stat.out_free)
                    state_next = stat.d_last ? S_NEND : S_NRD;
            end
            S_NEND: if (!stat.pend_valid || stat.out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: cmd.clr = 1'b1;
            S_IDLE: begin
                s_ready      = !cfg_valid;
                cfg_ready    = 1'b1;
                cmd.cfg_take = cfg_valid;
                cmd.take     = s_valid && !cfg_valid;
            end
            S_BDEC: cmd.bdec = 1'b1;
            S_SCAN: cmd.scan_run = 1'b1;
            S_SWR:  cmd.swr = 1'b1;
            S_EMIT: cmd.emit = stat.out_free;
            S_NDEC: begin
                cmd.ndec   = 1'b1;
                cmd.d_next = !stat.ndec_scan && !stat.d_last;
            end
            S_PUSH: begin
                cmd.push   = !stat.pend_valid || stat.out_free;
                cmd.d_next = cmd.push && !stat.d_last;
            end
            S_NEND: cmd.flush = stat.pend_valid && stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/pvr_dpath.sv @@
// Datapath of the route table: tables, path counter, neighbor scan and result registers.
`default_nettype none
module pvr_dpath
    import pvr_pkg::*;
#(
    parameter int NODES = PVR_NODES_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire pvr_cmd_t cmd,
    output pvr_stat_t     stat,
    input  wire pvr_in_t  s_data,
    input  wire logic [5:0] cfg_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output pvr_out_t      m_data
);

    localparam int SLOTS = (NODES < 64) ? NODES : 64;
    localparam int IW    = $clog2(SLOTS);
    localparam int AW    = 2 * IW;
    localparam int HW    = $clog2(NODES + 2);

    typedef struct packed {
        logic          valid;
        logic [IW-1:0] nxt;
        logic [HW-1:0] hops;
    } row_t;

    logic [HW-1:0] route_mem [2**AW];
    row_t          best_mem  [2**IW];

    logic [5:0]    self_reg;
    logic [HW-1:0] pc_reg;
    logic          loop_reg;
    logic [HW-1:0] h_reg;
    logic          bad_reg;
    logic [5:0]    n_reg;
    logic [5:0]    d_reg;
    logic          changed_reg;
    row_t          row_reg;
    logic [AW-1:0] clr_reg;
    logic [IW-1:0] scan_reg;
    logic [IW-1:0] scan_j_reg;
    logic          scan_v_reg;
    logic          found_reg;
    logic [HW-1:0] min_reg;
    logic [IW-1:0] min_j_reg;
    logic [HW-1:0] route_q;
    row_t          best_q;
    pvr_out_t      out_reg;
    logic          m_valid_reg;
    pvr_out_t      pend_reg;
    logic          pend_valid_reg;

    logic          n_ok, d_ok;
    logic [HW-1:0] pc_inc;
    logic          loop_now;
    logic [IW-1:0] n_idx, d_idx;
    logic          owns;
    logic          out_free;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [HW-1:0] wr_data;
    logic          wr_en;
    logic          best_we;
    logic [IW-1:0] best_wa;
    row_t          best_wd;
    row_t          bdec_row;
    logic          bdec_we;
    logic          bdec_chg;
    logic          bdec_scan;
    row_t          scan_row;
    pvr_out_t      res;
    pvr_kind_t     kind;

    assign n_idx    = n_reg[IW-1:0];
    assign d_idx    = d_reg[IW-1:0];
    assign n_ok     = {1'b0, s_data.neighbor} < 7'(SLOTS);
    assign d_ok     = {1'b0, s_data.dest} < 7'(SLOTS);
    assign pc_inc   = (pc_reg < HW'(NODES + 1)) ? pc_reg + 1'b1 : pc_reg;
    assign loop_now = loop_reg || (s_data.hop_node == self_reg);
    assign owns     = best_q.valid && (best_q.hops != '0) && (best_q.nxt == n_idx);
    assign out_free = !m_valid_reg || m_ready;

    // kind of the item on the input port
    always_comb begin
        kind = K_NONE;
        case (s_data.op)
            OP_PATH:     if (s_data.last && n_ok && d_ok) kind = K_ROUTE;
            OP_WITHDRAW: if (n_ok && d_ok) kind = K_ROUTE;
            OP_LOST:     if (n_ok) kind = K_LOST;
            default:     kind = K_NONE;
        endcase
    end

    // route update decision against the current best row
    always_comb begin
        bdec_row  = best_q;
        bdec_we   = 1'b0;
        bdec_chg  = 1'b0;
        bdec_scan = 1'b0;
        if (bad_reg) begin
            bdec_scan = owns;
            bdec_chg  = owns;
        end else if (!best_q.valid) begin
            bdec_row  = '{valid: 1'b1, nxt: n_idx, hops: h_reg};
            bdec_we   = 1'b1;
            bdec_chg  = 1'b1;
        end else if (owns) begin
            bdec_scan = 1'b1;
            bdec_chg  = 1'b1;
        end else if (best_q.hops > h_reg) begin
            bdec_row  = '{valid: 1'b1, nxt: n_idx, hops: h_reg};
            bdec_we   = 1'b1;
            bdec_chg  = 1'b1;
        end
    end

    assign scan_row = found_reg ? row_t'{valid: 1'b1, nxt: min_j_reg, hops: min_reg} : row_t'(0);

    always_comb begin
        rd_addr = cmd.scan_run ? {d_idx, scan_reg} : {d_idx, n_idx};
        wr_en   = 1'b0;
        wr_addr = {d_idx, n_idx};
        wr_data = '0;
        if (cmd.clr) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end else if (cmd.bdec) begin
            wr_en   = 1'b1;
            wr_data = bad_reg ? '0 : h_reg;
        end else if (cmd.ndec) begin
            wr_en   = route_q != '0;
        end
    end

    always_comb begin
        best_we = 1'b0;
        best_wa = d_idx;
        best_wd = scan_row;
        if (cmd.clr) begin
            best_wa = clr_reg[AW-1:IW];
            best_we = clr_reg[IW-1:0] == '0;
            best_wd = '0;
            if (6'(clr_reg[AW-1:IW]) == self_reg)
                best_wd = '{valid: 1'b1, nxt: clr_reg[AW-1:IW], hops: '0};
        end else if (cmd.bdec) begin
            best_we = bdec_we;
            best_wd = bdec_row;
        end else if (cmd.swr) begin
            best_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) route_mem[wr_addr] <= wr_data;
        route_q <= route_mem[rd_addr];
        if (best_we) best_mem[best_wa] <= best_wd;
        best_q <= best_mem[d_idx];
    end

    assign res = '{changed: 1'b1, dest_out: d_reg, next_hop: 6'(row_reg.nxt),
                   hops: 7'(row_reg.hops), reachable: row_reg.valid, last_out: 1'b0};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_reg       <= '0;
            pc_reg         <= '0;
            loop_reg       <= 1'b0;
            clr_reg        <= '0;
            scan_v_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            scan_v_reg <= cmd.scan_run;
            if (cmd.cfg_take) begin
                self_reg <= cfg_data;
                pc_reg   <= '0;
                loop_reg <= 1'b0;
                clr_reg  <= '0;
            end else if (cmd.clr) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.take && s_data.op == OP_PATH) begin
                if (s_data.last) begin
                    pc_reg   <= '0;
                    loop_reg <= 1'b0;
                end else begin
                    pc_reg   <= pc_inc;
                    loop_reg <= loop_now;
                end
            end
            if (out_free) m_valid_reg <= 1'b0;
            if (cmd.emit || cmd.flush || (cmd.push && pend_valid_reg))
                m_valid_reg <= 1'b1;
            if (cmd.push)  pend_valid_reg <= 1'b1;
            if (cmd.flush) pend_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            n_reg   <= s_data.neighbor;
            d_reg   <= (kind == K_LOST) ? '0 : s_data.dest;
            h_reg   <= pc_inc;
            bad_reg <= (s_data.op != OP_PATH) || loop_now || (pc_inc > HW'(NODES));
        end
        if (cmd.d_next) d_reg <= d_reg + 1'b1;
        if (cmd.bdec) begin
            changed_reg <= bdec_chg;
            row_reg     <= bdec_row;
        end
        if (cmd.swr) row_reg <= scan_row;
        if (cmd.bdec || cmd.ndec) begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan_run) begin
            scan_reg   <= scan_reg + 1'b1;
            scan_j_reg <= scan_reg;
        end
        // keep the first of equal minima, so the lowest neighbor wins
        if (scan_v_reg && route_q != '0 && (!found_reg || route_q < min_reg)) begin
            found_reg <= 1'b1;
            min_reg   <= route_q;
            min_j_reg <= scan_j_reg;
        end
        if (cmd.emit)
            out_reg <= '{changed: changed_reg, dest_out: d_reg,
                         next_hop: 6'(row_reg.nxt), hops: 7'(row_reg.hops),
                         reachable: row_reg.valid, last_out: 1'b1};
        if (cmd.push) begin
            pend_reg <= res;
            if (pend_valid_reg) out_reg <= pend_reg;
        end
        if (cmd.flush) begin
            out_reg          <= pend_reg;
            out_reg.last_out <= 1'b1;
        end
    end

    assign stat.kind       = kind;
    assign stat.clr_done   = clr_reg == '1;
    assign stat.bdec_scan  = bdec_scan;
    assign stat.ndec_scan  = (route_q != '0) && owns;
    assign stat.d_last     = d_idx == IW'(SLOTS - 1);
    assign stat.scan_last  = scan_reg == IW'(SLOTS - 1);
    assign stat.out_free   = out_free;
    assign stat.pend_valid = pend_valid_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

@@ hdl/path_vector_route_table_unit.sv @@
// Top level of the path vector route table.
// Keeps per destination and neighbor the advertised hop count and per destination the best
// next hop. After reset and after every self_id write the block sweeps its route memory once,
// one entry a cycle, and no item is taken meanwhile. A path element without last only updates
// the path counter and the loop flag. A final path element or a withdraw is decided against
// the destination's best row, and when the best neighbor has to be re-chosen it is found by
// scanning the destination's row through the one memory port. A neighbor loss walks all
// destinations and adds such a scan for every destination the lost neighbor served.
// Results leave through an output register, with one more held back so that the final
// result of a neighbor loss carries last_out.
`default_nettype none
module path_vector_route_table_unit
    import pvr_pkg::*;
#(
    parameter int NODES = PVR_NODES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire pvr_in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output pvr_out_t        m_data
);

    pvr_cmd_t  cmd;
    pvr_stat_t stat;

    pvr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pvr_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_data   (s_data),
        .cfg_data (cfg_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire
